// File: rtl/mme_pkg.sv
// Shared constants and types for the mismatch mask enumerator.
`default_nettype none
package mme_pkg;

    // Widest supported shape span and the default for the top level
    localparam int MAX_SPAN_DEF = 63;

    // Width of span, mismatch bound and level values
    localparam int CNT_W = 6;

    // Smallest legal span
    localparam logic [CNT_W-1:0] SPAN_MIN = CNT_W'(2);

    // Register values after reset
    localparam logic [CNT_W-1:0] SPAN_RST   = CNT_W'(2);
    localparam logic [CNT_W-1:0] MAX_MM_RST = CNT_W'(0);

    // Width of the request tdata: the restart flag, padded to a byte
    localparam int IN_TDATA_W = 8;

    // Configuration register index
    typedef enum logic [0:0] {
        REG_SPAN   = 1'b0,
        REG_MAX_MM = 1'b1
    } cfg_reg_t;

endpackage : mme_pkg
`default_nettype wire

// File: rtl/mismatch_mask_enumerator.sv
// Top level of the mismatch mask enumerator: next-combination step and output buffer.
//
// Usage:
//   Each request on the slave stream (s_tdata[0] = restart) returns one result
//   on the master stream. m_tdata holds the mask (set bits are kept positions
//   1..span-1, bit 0 always clear) and the mismatch count above it; m_tlast
//   flags the final mask of the enumeration; m_tuser is 1 when a mask is given
//   and 0 once the enumeration has finished (then mask and count are zero).
//   Masks come in order of mismatch count, and within one count in Gosper's
//   next-combination order of the cleared positions. restart=1 starts over at
//   zero mismatches before producing that request's result.
//   The user must write span and max_mismatches on the cfg port only while the
//   block is idle; the block does not enforce this. One request is taken every
//   cycle while s_tready is high, set by the single register stage holding the
//   enumeration state. A two-entry output buffer (main and skid register) keeps
//   s_tready a pure register output: while the receiver stalls the block takes
//   one more request, then holds s_tready low until the receiver takes a result.
//   Reset clears the enumeration state, empties the buffer and sets span=2,
//   max_mismatches=0.
`default_nettype none
module mismatch_mask_enumerator #(
    parameter int MAX_SPAN = mme_pkg::MAX_SPAN_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Request stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [mme_pkg::IN_TDATA_W-1:0]    s_tdata,  // [0] restart, rest zero
    // Result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // low to high: mask, mismatch_count, zero pad to whole bytes
    output logic [((MAX_SPAN+mme_pkg::CNT_W+7)/8)*8-1:0] m_tdata,
    output logic                                   m_tlast,  // last_mask
    output logic                                   m_tuser,  // valid_res
    // Configuration write port
    input  wire logic                              cfg_we,
    input  wire mme_pkg::cfg_reg_t                 cfg_addr,
    input  wire logic [mme_pkg::CNT_W-1:0]         cfg_wdata
);
    import mme_pkg::*;

    localparam int CW         = MAX_SPAN - 1;
    localparam int OUT_TDATA_W = ((MAX_SPAN + CNT_W + 7) / 8) * 8;
    localparam logic [CNT_W-1:0] SPAN_MAX = CNT_W'(MAX_SPAN);

    // Configuration registers
    logic [CNT_W-1:0] span_reg;
    logic [CNT_W-1:0] max_mm_reg;

    // Enumeration state
    logic [CW-1:0]    comb_reg, comb_next;
    logic [CNT_W-1:0] level_reg, level_next;
    logic             fin_reg, fin_next;

    // Output buffer
    logic                main_valid_reg, main_valid_next;
    logic [MAX_SPAN-1:0] main_mask_reg;
    logic [CNT_W-1:0]    main_cnt_reg;
    logic                main_last_reg;
    logic                main_ok_reg;
    logic                skid_valid_reg, skid_valid_next;
    logic [MAX_SPAN-1:0] skid_mask_reg;
    logic [CNT_W-1:0]    skid_cnt_reg;
    logic                skid_last_reg;
    logic                skid_ok_reg;

    // Step signals
    logic                push, pop;
    logic                restart;
    logic [CNT_W-1:0]    span_c, n_c, kmax_c;
    logic [MAX_SPAN-1:0] fit_w;
    logic [CW-1:0]       comb_cur;
    logic [CNT_W-1:0]    level_cur;
    logic                fin_cur;
    logic [CNT_W-1:0]    ctz;
    logic                ctz_found;
    logic [MAX_SPAN-1:0] c_w, t_w, tp1_w, low_w, next_w;
    logic                overflow;
    logic [MAX_SPAN-1:0] res_mask;
    logic [CNT_W-1:0]    res_cnt;
    logic                res_last;
    logic                res_ok;

    assign push    = s_tvalid && s_tready;
    assign pop     = m_tvalid && m_tready;
    assign restart = s_tdata[0];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg   <= SPAN_RST;
            max_mm_reg <= MAX_MM_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_SPAN:   span_reg   <= cfg_wdata;
                REG_MAX_MM: max_mm_reg <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // Clamp span and mismatch bound
    always_comb
    begin
        if (span_reg < SPAN_MIN)
            span_c = SPAN_MIN;
        else if (span_reg > SPAN_MAX)
            span_c = SPAN_MAX;
        else
            span_c = span_reg;
        n_c    = span_c - CNT_W'(1);
        kmax_c = (max_mm_reg > n_c) ? n_c : max_mm_reg;
    end

    // Mark positions that fit in span-1 bits
    always_comb
    begin
        for (int i = 0; i < MAX_SPAN; i++)
            fit_w[i] = (CNT_W'(i) < n_c);
    end

    // Apply restart ahead of the step
    always_comb
    begin
        comb_cur  = restart ? '0 : comb_reg;
        level_cur = restart ? '0 : level_reg;
        fin_cur   = restart ? 1'b0 : fin_reg;
    end

    // Find lowest set position of the combination
    always_comb
    begin
        ctz       = '0;
        ctz_found = 1'b0;
        for (int i = 0; i < CW; i++)
        begin
            if (!ctz_found && comb_cur[i])
            begin
                ctz       = CNT_W'(i);
                ctz_found = 1'b1;
            end
        end
    end

    // Gosper next combination, one bit wider to catch the carry
    always_comb
    begin
        c_w    = {1'b0, comb_cur};
        t_w    = c_w | (c_w - MAX_SPAN'(1));
        tp1_w  = t_w + MAX_SPAN'(1);
        low_w  = (~t_w & tp1_w) - MAX_SPAN'(1);
        next_w = tp1_w | (low_w >> (ctz + CNT_W'(1)));
        overflow = (level_cur == '0) || (|(next_w & ~fit_w));
    end

    // Produce the result and the next enumeration state
    always_comb
    begin
        logic fin_chk;
        fin_chk    = fin_cur || (level_cur > kmax_c) || (|(comb_cur & ~fit_w[CW-1:0]));
        comb_next  = comb_cur;
        level_next = level_cur;
        fin_next   = fin_chk;
        res_mask   = '0;
        res_cnt    = '0;
        res_last   = 1'b0;
        res_ok     = 1'b0;
        if (!fin_chk)
        begin
            res_ok = 1'b1;
            res_cnt = level_cur;
            for (int i = 0; i < CW; i++)
                res_mask[i+1] = ~comb_cur[i] & fit_w[i];
            if (overflow)
            begin
                if (level_cur >= kmax_c)
                begin
                    res_last   = 1'b1;
                    fin_next   = 1'b1;
                    comb_next  = '0;
                    level_next = '0;
                end
                else
                begin
                    level_next = level_cur + CNT_W'(1);
                    for (int i = 0; i < CW; i++)
                        comb_next[i] = (CNT_W'(i) <= level_cur);
                end
            end
            else
            begin
                comb_next = next_w[CW-1:0];
            end
        end
    end

    // Advance enumeration state on each request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comb_reg  <= '0;
            level_reg <= '0;
            fin_reg   <= 1'b0;
        end
        else if (push)
        begin
            comb_reg  <= comb_next;
            level_reg <= level_next;
            fin_reg   <= fin_next;
        end
    end

    // Output buffer occupancy
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop || !main_valid_reg)
        begin
            main_valid_next = skid_valid_reg || push;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Load main from skid or from the new result; hold skid while main stalls
    always_ff @(posedge clk)
    begin
        if (pop || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_mask_reg <= skid_mask_reg;
                main_cnt_reg  <= skid_cnt_reg;
                main_last_reg <= skid_last_reg;
                main_ok_reg   <= skid_ok_reg;
            end
            else if (push)
            begin
                main_mask_reg <= res_mask;
                main_cnt_reg  <= res_cnt;
                main_last_reg <= res_last;
                main_ok_reg   <= res_ok;
            end
        end
        else if (push)
        begin
            skid_mask_reg <= res_mask;
            skid_cnt_reg  <= res_cnt;
            skid_last_reg <= res_last;
            skid_ok_reg   <= res_ok;
        end
    end

    // Drive stream outputs
    assign s_tready = !skid_valid_reg;
    assign m_tvalid = main_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({main_cnt_reg, main_mask_reg});
    assign m_tlast  = main_last_reg;
    assign m_tuser  = main_ok_reg;

`ifndef SYNTHESIS
    // Skid entry only ever backs up a full main register
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid register holds a result while main is empty");

    // A given mask never keeps position zero
    a_bit0_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> !main_mask_reg[0])
        else $error("mask keeps position zero");

    // Final mask is always a real mask
    a_last_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("last mask flagged on a finished result");

    // Finished results carry no mask and no count
    a_finished_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (main_mask_reg == '0 && main_cnt_reg == '0))
        else $error("finished result carries data");

    // Emitting the final mask leaves the enumeration finished
    a_last_sets_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (push && res_last) |=> fin_reg)
        else $error("enumeration not finished after last mask");
`endif

endmodule : mismatch_mask_enumerator
`default_nettype wire
